// ===== rtl/bhps_pkg.sv =====
package bhps_pkg;

  // Loop constants
  localparam int SAMPLE_PERIOD = 50;
  localparam int PULSE_CYCLE   = 2000;

  // Field widths
  localparam int LEFT_W  = 2;
  localparam int RIGHT_W = 3;
  localparam int WHEEL_W = 11;
  localparam int ANGLE_W = 32;
  localparam int SPEED_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int THR_W   = 15;

  // Counter widths
  localparam int SP_W   = $clog2(SAMPLE_PERIOD + 1);
  localparam int PT_W   = $clog2(PULSE_CYCLE + 2);
  localparam int TICK_W = CFG_W + 1;

  // Stream widths
  localparam int IN_BITS  = LEFT_W + RIGHT_W + 2 * WHEEL_W + ANGLE_W + SPEED_W;
  localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ANGLE_W + 3 + 2;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

  // Result bit positions in out_tdata
  localparam int OB_STOP     = ANGLE_W;
  localparam int OB_DIR      = ANGLE_W + 1;
  localparam int OB_LIMIT    = ANGLE_W + 2;
  localparam int OB_PHASE_LO = ANGLE_W + 3;

  // Switch codes
  localparam logic [LEFT_W-1:0]  LEFT_MANUAL   = 2'd3;
  localparam logic [LEFT_W-1:0]  LEFT_DISABLE  = 2'd2;
  localparam logic [RIGHT_W-1:0] RIGHT_HOMING  = 3'd2;
  localparam logic [RIGHT_W-1:0] RIGHT_THRESH  = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE       = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0]          RST_STALL_THR    = 16'd200;
  localparam logic [CFG_W-1:0]          RST_DRIVE_OFFSET = 16'd999;
  localparam logic [CFG_W-1:0]          RST_SETTLE       = 16'd200;
  localparam logic [CFG_W-1:0]          RST_OVERSHOOT    = 16'd200;
  localparam logic [THR_W-1:0]          RST_SPEED_THR    = 15'd1000;
  localparam logic signed [WHEEL_W-1:0] RST_ENGAGE       = 11'sd300;

  // Pulse sequence marks
  localparam int PULSE_FLIP     = 45;
  localparam int PULSE_STOP_END = 50;
  localparam int PULSE_RECENTRE = 200;

  // Threshold mode wheel window
  localparam logic signed [WHEEL_W-1:0] WHEEL_WIN_LO = -11'sd100;
  localparam logic signed [WHEEL_W-1:0] WHEEL_WIN_HI = 11'sd200;

  // Homing phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_TOP    = 4'b0010,
    PH_BOTTOM = 4'b0100,
    PH_HOMED  = 4'b1000
  } phase_t;

  localparam logic [1:0] PCODE_IDLE   = 2'd0;
  localparam logic [1:0] PCODE_TOP    = 2'd1;
  localparam logic [1:0] PCODE_BOTTOM = 2'd2;
  localparam logic [1:0] PCODE_HOMED  = 2'd3;

  typedef struct packed {
    logic [LEFT_W-1:0]         left_switch;
    logic [RIGHT_W-1:0]        right_switch;
    logic signed [WHEEL_W-1:0] wheel_value;
    logic signed [WHEEL_W-1:0] stick_value;
    logic signed [ANGLE_W-1:0] brake_angle;
    logic signed [SPEED_W-1:0] chassis_speed;
  } item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] target_angle;
    logic                      chassis_stop;
    logic                      drive_direction;
    logic                      high_speed_limit;
    logic [1:0]                homing_phase;
  } res_t;

  function automatic logic [1:0] phase_code(phase_t p);
    logic [1:0] c;
    case (p)
      PH_IDLE:   c = PCODE_IDLE;
      PH_TOP:    c = PCODE_TOP;
      PH_BOTTOM: c = PCODE_BOTTOM;
      PH_HOMED:  c = PCODE_HOMED;
      default:   c = PCODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bhps_in_reg.sv =====
module bhps_in_reg
  import bhps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,
  input  logic              advance,
  output logic              item_valid,
  output item_t             item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  // Hold the waiting item flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Unpack an accepted item
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.left_switch   <= in_tdata[1:0];
      item_r.right_switch  <= in_tdata[4:2];
      item_r.wheel_value   <= in_tdata[15:5];
      item_r.stick_value   <= in_tdata[26:16];
      item_r.brake_angle   <= in_tdata[58:27];
      item_r.chassis_speed <= in_tdata[74:59];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/bhps_core.sv =====
module bhps_core
  import bhps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 advance,
  input  item_t                item,
  output res_t                 res
);

  // Configuration
  logic [CFG_W-1:0]          stall_thr_r, drive_off_r, settle_r, overshoot_r;
  logic [THR_W-1:0]          speed_thr_r;
  logic signed [WHEEL_W-1:0] engage_r;

  // Sequencer state
  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [SP_W-1:0]     sample_r, sample_nxt;
  logic [ANGLE_W-1:0]  prev_r, prev_nxt;
  logic [ANGLE_W-1:0]  delta_r, delta_nxt;
  logic [ANGLE_W-1:0]  top_r, top_nxt;
  logic [ANGLE_W-1:0]  bottom_r, bottom_nxt;
  logic [ANGLE_W-1:0]  centre_r, centre_nxt;
  logic [ANGLE_W-1:0]  setpoint_r, setpoint_nxt;
  logic                req_r, req_nxt;
  logic [PT_W-1:0]     timer_r, timer_nxt;
  logic                stop_r, stop_nxt;
  logic                dir_r, dir_nxt;
  logic                limit_r, limit_nxt;

  // Datapath terms
  logic                manual, homing_mode, stalled;
  logic [SP_W-1:0]     sample_inc;
  logic signed [ANGLE_W:0] delta_s, thr_s, sum_s, sum_adj;
  logic signed [SPEED_W:0] speed_s, speed_thr_s;
  logic [ANGLE_W-1:0]  angle_u, centre_calc;
  logic [ANGLE_W-1:0]  over_top, over_bottom, drive_up, drive_down;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_thr_r <= RST_STALL_THR;
      drive_off_r <= RST_DRIVE_OFFSET;
      settle_r    <= RST_SETTLE;
      overshoot_r <= RST_OVERSHOOT;
      speed_thr_r <= RST_SPEED_THR;
      engage_r    <= RST_ENGAGE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STALL_THR:    stall_thr_r <= cfg_wdata;
        CFG_DRIVE_OFFSET: drive_off_r <= cfg_wdata;
        CFG_SETTLE:       settle_r    <= cfg_wdata;
        CFG_OVERSHOOT:    overshoot_r <= cfg_wdata;
        CFG_SPEED_THR:    speed_thr_r <= cfg_wdata[THR_W-1:0];
        CFG_ENGAGE:       engage_r    <= cfg_wdata[WHEEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Precompute angle sums in parallel
  assign angle_u     = item.brake_angle;
  assign drive_up    = angle_u + {{(ANGLE_W-CFG_W){1'b0}}, drive_off_r};
  assign drive_down  = angle_u - {{(ANGLE_W-CFG_W){1'b0}}, drive_off_r};
  assign over_top    = top_r + {{(ANGLE_W-CFG_W){1'b0}}, overshoot_r};

  // Midpoint of the new bottom and the stored top, truncated toward zero
  assign sum_s       = $signed({angle_u[ANGLE_W-1], angle_u}) +
                       $signed({top_r[ANGLE_W-1], top_r});
  assign sum_adj     = sum_s + $signed({{ANGLE_W{1'b0}}, sum_s[ANGLE_W]});
  assign centre_calc = sum_adj[ANGLE_W:1];

  assign speed_s     = $signed({item.chassis_speed[SPEED_W-1], item.chassis_speed});
  assign speed_thr_s = $signed({2'b00, speed_thr_r});
  assign thr_s       = $signed({{(ANGLE_W+1-CFG_W){1'b0}}, stall_thr_r});
  assign sample_inc  = sample_r + 1'b1;

  assign manual      = (item.left_switch == LEFT_MANUAL);
  assign homing_mode = manual && (item.right_switch == RIGHT_HOMING);

  // One tick of the sequencer
  always_comb begin
    phase_nxt    = phase_r;
    ticks_nxt    = ticks_r;
    sample_nxt   = sample_r;
    prev_nxt     = prev_r;
    delta_nxt    = delta_r;
    top_nxt      = top_r;
    bottom_nxt   = bottom_r;
    centre_nxt   = centre_r;
    setpoint_nxt = setpoint_r;
    req_nxt      = req_r;
    timer_nxt    = timer_r;
    stop_nxt     = stop_r;
    dir_nxt      = dir_r;
    limit_nxt    = limit_r;

    if (homing_mode) begin
      req_nxt = (item.wheel_value > engage_r);
    end

    // Advance tick counter and sampler
    if (ticks_r != {TICK_W{1'b1}}) begin
      ticks_nxt = ticks_r + 1'b1;
    end
    sample_nxt = sample_inc;
    if (sample_inc >= SP_W'(SAMPLE_PERIOD)) begin
      sample_nxt = '0;
      delta_nxt  = angle_u - prev_r;
      prev_nxt   = angle_u;
    end

    delta_s = $signed({delta_nxt[ANGLE_W-1], delta_nxt});
    stalled = (ticks_nxt > {1'b0, settle_r}) && (delta_s < thr_s) && (delta_s > -thr_s);

    // Homing phases
    if (homing_mode) begin
      case (phase_r)
        PH_IDLE: begin
          if (req_nxt) begin
            phase_nxt  = PH_TOP;
            ticks_nxt  = '0;
            sample_nxt = '0;
          end
        end
        PH_TOP: begin
          limit_nxt    = 1'b0;
          setpoint_nxt = drive_up;
          if (stalled) begin
            top_nxt    = angle_u;
            phase_nxt  = PH_BOTTOM;
            ticks_nxt  = '0;
            sample_nxt = '0;
          end
        end
        PH_BOTTOM: begin
          limit_nxt    = 1'b0;
          setpoint_nxt = drive_down;
          if (stalled) begin
            bottom_nxt   = angle_u;
            centre_nxt   = centre_calc;
            setpoint_nxt = centre_calc;
            limit_nxt    = 1'b1;
            phase_nxt    = PH_HOMED;
          end
        end
        default: ;
      endcase
    end

    // Abort on the disable switch
    if (item.left_switch == LEFT_DISABLE) begin
      ticks_nxt  = '0;
      sample_nxt = '0;
      if (phase_nxt == PH_TOP || phase_nxt == PH_BOTTOM) begin
        phase_nxt = PH_IDLE;
      end
    end

    // Overshoot below the bottom end, which may have been latched this tick
    over_bottom = bottom_nxt - {{(ANGLE_W-CFG_W){1'b0}}, overshoot_r};

    // Pulse sequence
    if (manual && phase_nxt == PH_HOMED) begin
      if (!req_nxt) begin
        setpoint_nxt = centre_nxt;
        stop_nxt     = 1'b0;
        timer_nxt    = '0;
        if (item.stick_value == '0) begin
          dir_nxt = 1'b0;
        end
      end else begin
        if (timer_r == '0) begin
          timer_nxt = PT_W'(2);
          stop_nxt  = 1'b1;
        end else begin
          timer_nxt = timer_r + 1'b1;
        end
        if (timer_nxt == PT_W'(PULSE_FLIP)) begin
          dir_nxt = !dir_r;
        end
        if (timer_nxt > PT_W'(PULSE_STOP_END)) begin
          stop_nxt = 1'b0;
        end
        if (timer_nxt < PT_W'(PULSE_STOP_END)) begin
          if (speed_s > speed_thr_s) begin
            setpoint_nxt = over_top;
          end
          if (speed_s < -speed_thr_s) begin
            setpoint_nxt = over_bottom;
          end
        end
        if (timer_nxt > PT_W'(PULSE_RECENTRE)) begin
          setpoint_nxt = centre_nxt;
          stop_nxt     = 1'b0;
        end
        if (timer_nxt > PT_W'(PULSE_CYCLE)) begin
          timer_nxt = '0;
        end
      end
    end

    // Wheel threshold mode
    if (manual && item.right_switch == RIGHT_THRESH && phase_nxt == PH_HOMED) begin
      if (item.wheel_value >= WHEEL_WIN_LO && item.wheel_value <= WHEEL_WIN_HI) begin
        setpoint_nxt = centre_nxt;
      end else if (item.wheel_value > WHEEL_WIN_HI) begin
        if (item.chassis_speed > $signed(SPEED_W'(0))) begin
          setpoint_nxt = over_bottom;
        end
      end
    end
  end

  // Commit state for each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      ticks_r    <= '0;
      sample_r   <= '0;
      prev_r     <= '0;
      delta_r    <= '0;
      top_r      <= '0;
      bottom_r   <= '0;
      centre_r   <= '0;
      setpoint_r <= '0;
      req_r      <= 1'b0;
      timer_r    <= '0;
      stop_r     <= 1'b0;
      dir_r      <= 1'b0;
      limit_r    <= 1'b0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      ticks_r    <= ticks_nxt;
      sample_r   <= sample_nxt;
      prev_r     <= prev_nxt;
      delta_r    <= delta_nxt;
      top_r      <= top_nxt;
      bottom_r   <= bottom_nxt;
      centre_r   <= centre_nxt;
      setpoint_r <= setpoint_nxt;
      req_r      <= req_nxt;
      timer_r    <= timer_nxt;
      stop_r     <= stop_nxt;
      dir_r      <= dir_nxt;
      limit_r    <= limit_nxt;
    end
  end

  // Result of this tick
  assign res.target_angle     = setpoint_nxt;
  assign res.chassis_stop     = stop_nxt;
  assign res.drive_direction  = dir_nxt;
  assign res.high_speed_limit = limit_nxt;
  assign res.homing_phase     = phase_code(phase_nxt);

endmodule

// ===== rtl/bhps_out_reg.sv =====
module bhps_out_reg
  import bhps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  res_t              res,
  output logic              can_load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  // Track the pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TW-OUT_BITS){1'b0}}, res_r.homing_phase,
                       res_r.high_speed_limit, res_r.drive_direction,
                       res_r.chassis_stop, res_r.target_angle};

endmodule

// ===== rtl/brake_homing_and_pulse_sequencer.sv =====
// Channel  Dir  Handshake           Payload
// in       in   in_tvalid/tready    in_tdata: one control tick (80 bits)
// out      out  out_tvalid/tready   out_tdata: target angle and flags (40 bits)
// cfg      in   cfg_we              cfg_index selects register, cfg_wdata value
//
// An item is held in the input register and is computed into the result register
// when it advances; one item per cycle while the result side is not stalled.
// Each tick updates the homing and pulse state at the same edge that loads its result.
// Synchronous active-low reset clears the valid flags and sequencer state and restores register defaults.
// A stalled result holds its item; the input register still takes one more item.
module brake_homing_and_pulse_sequencer
  import bhps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // left_switch[1:0], right_switch[4:2], wheel_value[15:5], stick_value[26:16],
  // brake_angle[58:27], chassis_speed[74:59], zero fill
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_TW-1:0]     in_tdata,
  // target_angle[31:0], chassis_stop[32], drive_direction[33],
  // high_speed_limit[34], homing_phase[36:35], zero fill
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_TW-1:0]    out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic  item_valid, can_load, advance;
  item_t item;
  res_t  res;

  assign advance = item_valid && can_load;

  bhps_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bhps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .res       (res)
  );

  bhps_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // Input blocks only behind a full input register and a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (item_valid && out_tvalid && !out_tready))
    else $error("input blocked without a stalled result");

  // Wide speed limit is only selected once homed
  a_limit_homed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OB_LIMIT]) |->
      (out_tdata[OB_PHASE_LO+1:OB_PHASE_LO] == PCODE_HOMED))
    else $error("speed limit raised outside homed phase");

  // Chassis stop is only requested by the pulse sequence
  a_stop_homed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OB_STOP]) |->
      (out_tdata[OB_PHASE_LO+1:OB_PHASE_LO] == PCODE_HOMED))
    else $error("chassis stop outside homed phase");

  // A processed item always leaves a result behind
  a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("processed item left no result");
`endif

endmodule

// ===== dv/tb_brake_homing_and_pulse_sequencer.sv =====
module tb_brake_homing_and_pulse_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import bhps_pkg::*;

  // Switch codes with no named meaning in the package
  localparam logic [LEFT_W-1:0]  LEFT_NONE    = 2'd0;
  localparam logic [LEFT_W-1:0]  LEFT_AUTO    = 2'd1;
  localparam logic [RIGHT_W-1:0] RIGHT_NONE   = 3'd0;
  localparam logic [RIGHT_W-1:0] RIGHT_PLAIN  = 3'd1;
  localparam logic [RIGHT_W-1:0] RIGHT_UNUSED = 3'd7;

  typedef enum int {SEG_PULSE, SEG_RELEASE, SEG_THRESH, SEG_NOISE} seg_kind_t;

  // Brake state tracker and store of pending results
  class brake_scoreboard;
    logic [CFG_W-1:0]          stall_thr    = RST_STALL_THR;
    logic [CFG_W-1:0]          drive_offset = RST_DRIVE_OFFSET;
    logic [CFG_W-1:0]          settle       = RST_SETTLE;
    logic [CFG_W-1:0]          overshoot    = RST_OVERSHOOT;
    logic [THR_W-1:0]          speed_thr    = RST_SPEED_THR;
    logic signed [WHEEL_W-1:0] engage_lvl   = RST_ENGAGE;

    logic [1:0]  phase        = PCODE_IDLE;
    logic [31:0] homing_ticks = '0;
    logic [5:0]  sample_cnt   = '0;
    logic [31:0] prev_angle   = '0;
    logic [31:0] angle_delta  = '0;
    logic [31:0] top_end      = '0;
    logic [31:0] bottom_end   = '0;
    logic [31:0] centre       = '0;
    logic [31:0] target       = '0;
    logic [11:0] pulse_count  = '0;
    bit request, stop, dir, limit;

    res_t expected_outputs[$];
    int   mismatches;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_STALL_THR:    stall_thr    = v;
        CFG_DRIVE_OFFSET: drive_offset = v;
        CFG_SETTLE:       settle       = v;
        CFG_OVERSHOOT:    overshoot    = v;
        CFG_SPEED_THR:    speed_thr    = v[THR_W-1:0];
        CFG_ENGAGE:       engage_lvl   = v[WHEEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void restart_homing_count();
      homing_ticks = '0;
      sample_cnt   = '0;
    endfunction

    // Advance one control tick and return the result it produces
    function res_t advance_tick(item_t it);
      bit          manual, hmode, stalled;
      int          wheel, stick, speed, thr;
      logic [31:0] angle, mag;
      longint      sum;
      res_t        r;
      wheel  = it.wheel_value;
      stick  = it.stick_value;
      speed  = it.chassis_speed;
      thr    = speed_thr;
      angle  = it.brake_angle;
      manual = (it.left_switch == LEFT_MANUAL);
      hmode  = manual && (it.right_switch == RIGHT_HOMING);

      if (hmode) request = (wheel > engage_lvl);

      // Count ticks and take an angle sample each period
      if (homing_ticks != '1) homing_ticks++;
      sample_cnt++;
      if (sample_cnt >= SAMPLE_PERIOD) begin
        sample_cnt  = '0;
        angle_delta = angle - prev_angle;
        prev_angle  = angle;
      end
      mag = angle_delta[31] ? (32'd0 - angle_delta) : angle_delta;
      stalled = (homing_ticks > {16'd0, settle}) && (mag < {16'd0, stall_thr});

      // Homing walk: top end, then bottom end, then store midpoint
      if (hmode) begin
        case (phase)
          PCODE_IDLE: begin
            if (request) begin
              phase = PCODE_TOP;
              restart_homing_count();
            end
          end
          PCODE_TOP: begin
            limit  = 1'b0;
            target = angle + {16'd0, drive_offset};
            if (stalled) begin
              top_end = angle;
              phase   = PCODE_BOTTOM;
              restart_homing_count();
            end
          end
          PCODE_BOTTOM: begin
            limit  = 1'b0;
            target = angle - {16'd0, drive_offset};
            if (stalled) begin
              bottom_end = angle;
              sum    = longint'($signed(bottom_end)) + longint'($signed(top_end));
              centre = 32'(sum / 2);
              target = centre;
              limit  = 1'b1;
              phase  = PCODE_HOMED;
            end
          end
          default: ;
        endcase
      end

      // Disable switch drops a half-done homing run
      if (it.left_switch == LEFT_DISABLE) begin
        restart_homing_count();
        if (phase == PCODE_TOP || phase == PCODE_BOTTOM) phase = PCODE_IDLE;
      end

      // Timed brake pulse once homed
      if (manual && phase == PCODE_HOMED) begin
        if (!request) begin
          target      = centre;
          stop        = 1'b0;
          pulse_count = '0;
          if (stick == 0) dir = 1'b0;
        end else begin
          if (pulse_count == 0) begin
            pulse_count = 12'd1;
            stop        = 1'b1;
          end
          pulse_count++;
          if (pulse_count == PULSE_FLIP) dir = !dir;
          if (pulse_count > PULSE_STOP_END) stop = 1'b0;
          if (pulse_count < PULSE_STOP_END) begin
            if (speed > thr) target = top_end + {16'd0, overshoot};
            if (speed < -thr) target = bottom_end - {16'd0, overshoot};
          end
          if (pulse_count > PULSE_RECENTRE) begin
            target = centre;
            stop   = 1'b0;
          end
          if (pulse_count > PULSE_CYCLE) pulse_count = '0;
        end
      end

      // Wheel-threshold mode
      if (manual && it.right_switch == RIGHT_THRESH && phase == PCODE_HOMED) begin
        if (wheel >= WHEEL_WIN_LO && wheel <= WHEEL_WIN_HI) target = centre;
        else if (wheel >= WHEEL_WIN_HI && speed > 0)
          target = bottom_end - {16'd0, overshoot};
      end

      r.target_angle     = target;
      r.chassis_stop     = stop;
      r.drive_direction  = dir;
      r.high_speed_limit = limit;
      r.homing_phase     = phase;
      return r;
    endfunction

    function void note_tick(item_t it);
      expected_outputs.push_back(advance_tick(it));
    endfunction

    function void report(string name, logic [31:0] e, logic [31:0] a);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      mismatches++;
    endfunction

    function void check_result(logic [OUT_TW-1:0] d);
      res_t want, got;
      got.target_angle     = d[ANGLE_W-1:0];
      got.chassis_stop     = d[OB_STOP];
      got.drive_direction  = d[OB_DIR];
      got.high_speed_limit = d[OB_LIMIT];
      got.homing_phase     = d[OB_PHASE_LO +: 2];
      if (expected_outputs.size() == 0) begin
        $display("%0t ns: result with nothing pending, expected none, actual %h",
                 $time, d);
        mismatches++;
        return;
      end
      want = expected_outputs.pop_front();
      if (got.target_angle !== want.target_angle)
        report("target_angle", want.target_angle, got.target_angle);
      if (got.chassis_stop !== want.chassis_stop)
        report("chassis_stop", want.chassis_stop, got.chassis_stop);
      if (got.drive_direction !== want.drive_direction)
        report("drive_direction", want.drive_direction, got.drive_direction);
      if (got.high_speed_limit !== want.high_speed_limit)
        report("high_speed_limit", want.high_speed_limit, got.high_speed_limit);
      if (got.homing_phase !== want.homing_phase)
        report("homing_phase", want.homing_phase, got.homing_phase);
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_TW-1:0]     in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_TW-1:0]    out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  int          in_gap_pct  = 34;
  int          out_gap_pct = 34;
  logic [31:0] cur_angle   = '0;
  brake_scoreboard sb = new;

  brake_homing_and_pulse_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Check results and stall the result side at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= out_gap_pct);
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int request_wheel();
    int e;
    e = sb.engage_lvl;
    return (e >= 660) ? 660 : rand_between(e + 1, 660);
  endfunction

  function automatic int pick_stick();
    return ($urandom_range(0, 1) == 0) ? 0 : rand_between(-660, 660);
  endfunction

  function automatic logic [15:0] pick_speed();
    int t;
    t = sb.speed_thr;
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(t + rand_between(-2, 2));
      2:       return 16'(-t + rand_between(-2, 2));
      default: return 16'(rand_between(-50, 50));
    endcase
  endfunction

  function automatic int pick_thresh_wheel();
    case ($urandom_range(0, 7))
      0:       return -101;
      1:       return -100;
      2:       return 200;
      3:       return 201;
      4:       return -660;
      5:       return 660;
      default: return rand_between(-660, 660);
    endcase
  endfunction

  function automatic logic [31:0] walk_angle();
    if ($urandom_range(0, 49) == 0) cur_angle = $urandom;
    else cur_angle = cur_angle + 32'(rand_between(-3000, 3000));
    return cur_angle;
  endfunction

  function automatic item_t random_tick();
    item_t it;
    it.left_switch   = LEFT_W'($urandom_range(0, 3));
    it.right_switch  = RIGHT_W'($urandom_range(0, 7));
    it.wheel_value   = WHEEL_W'(rand_between(-660, 660));
    it.stick_value   = WHEEL_W'(rand_between(-660, 660));
    it.brake_angle   = $urandom;
    it.chassis_speed = 16'($urandom);
    return it;
  endfunction

  // Present one item, hold it until taken, then log it
  task automatic send_tick(input item_t it);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TW - IN_BITS){1'b0}}, it.chassis_speed, it.brake_angle,
                  it.stick_value, it.wheel_value, it.right_switch, it.left_switch};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(it);
  endtask

  task automatic send_fields(input logic [LEFT_W-1:0] l, input logic [RIGHT_W-1:0] r,
                             input int w, input int s, input logic [31:0] a,
                             input int sp);
    item_t it;
    it.left_switch   = l;
    it.right_switch  = r;
    it.wheel_value   = WHEEL_W'(w);
    it.stick_value   = WHEEL_W'(s);
    it.brake_angle   = a;
    it.chassis_speed = 16'(sp);
    send_tick(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(input int stall, input int offset, input int settle_v,
                                input int over, input int spd, input int engage);
    write_reg(CFG_STALL_THR, CFG_W'(stall));
    write_reg(CFG_DRIVE_OFFSET, CFG_W'(offset));
    write_reg(CFG_SETTLE, CFG_W'(settle_v));
    write_reg(CFG_OVERSHOOT, CFG_W'(over));
    write_reg(CFG_SPEED_THR, CFG_W'(spd));
    write_reg(CFG_ENGAGE, CFG_W'(engage));
    cfg_we <= 1'b0;
  endtask

  task automatic apply_random_settings();
    apply_settings(rand_between(0, 3000), $urandom_range(0, 65535), rand_between(0, 300),
                   $urandom_range(0, 65535), $urandom_range(0, 32767),
                   rand_between(-660, 660));
  endtask

  // Drop valid and wait until every pending result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drive the brake out to each end and hold it there until the stall is seen
  task automatic run_homing(input int cap);
    int         sent, ramp_len;
    logic [1:0] seen_phase;
    item_t      it;
    sent       = 0;
    ramp_len   = 150;
    seen_phase = sb.phase;
    cur_angle  = $urandom;
    while (sb.phase != PCODE_HOMED && sent < cap) begin
      if (sb.phase != seen_phase) begin
        seen_phase = sb.phase;
        ramp_len   = rand_between(100, 260);
      end
      if ($urandom_range(0, 99) < 2) begin
        it = random_tick();
      end else begin
        it.left_switch   = LEFT_MANUAL;
        it.right_switch  = RIGHT_HOMING;
        it.wheel_value   = WHEEL_W'(($urandom_range(0, 9) != 0) ? request_wheel()
                                    : rand_between(-660, sb.engage_lvl));
        it.stick_value   = WHEEL_W'(pick_stick());
        it.chassis_speed = pick_speed();
        if (sb.phase == PCODE_TOP && sb.homing_ticks < ramp_len)
          cur_angle = cur_angle + 32'(rand_between(500, 1500));
        else if (sb.phase == PCODE_BOTTOM && sb.homing_ticks < ramp_len)
          cur_angle = cur_angle - 32'(rand_between(500, 1500));
        else if (sb.phase == PCODE_BOTTOM)
          cur_angle[0] = ~sb.top_end[0];  // odd end sum exercises midpoint rounding
        it.brake_angle = cur_angle;
      end
      send_tick(it);
      sent++;
    end
  endtask

  task automatic drive_segment(input seg_kind_t kind, input int len, input int thresh_pct);
    item_t it;
    repeat (len) begin
      it.left_switch   = LEFT_MANUAL;
      it.right_switch  = RIGHT_HOMING;
      it.stick_value   = WHEEL_W'(pick_stick());
      it.brake_angle   = walk_angle();
      it.chassis_speed = pick_speed();
      case (kind)
        SEG_PULSE: begin
          if ($urandom_range(0, 99) < thresh_pct) it.right_switch = RIGHT_THRESH;
          it.wheel_value = WHEEL_W'(request_wheel());
        end
        SEG_RELEASE: it.wheel_value = WHEEL_W'(rand_between(-660, sb.engage_lvl));
        SEG_THRESH: begin
          it.right_switch = RIGHT_THRESH;
          it.wheel_value  = WHEEL_W'(pick_thresh_wheel());
        end
        default: it = random_tick();
      endcase
      send_tick(it);
    end
  endtask

  // Mix pulse runs, releases, threshold stretches and noise
  task automatic run_free(input int count);
    int sent, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        drive_segment(SEG_PULSE, rand_between(20, 260), 10);
        sent += 140;
      end else if (pick < 65) begin
        drive_segment(SEG_RELEASE, rand_between(3, 30), 0);
        sent += 16;
      end else if (pick < 85) begin
        drive_segment(SEG_THRESH, rand_between(5, 40), 0);
        sent += 22;
      end else begin
        drive_segment(SEG_NOISE, rand_between(1, 8), 0);
        sent += 4;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: odd switch codes, field extremes, aborts in both homing phases
    apply_settings(65535, 999, 1, 200, 1000, 300);
    send_fields(LEFT_NONE, RIGHT_NONE, 0, 0, 32'h0, 0);
    send_fields(LEFT_AUTO, RIGHT_UNUSED, 660, -660, 32'h7FFF_FFFF, 32767);
    send_fields(LEFT_DISABLE, RIGHT_HOMING, -660, 660, 32'h8000_0000, -32768);
    send_fields(LEFT_MANUAL, RIGHT_THRESH, 201, 0, 32'd100, 500);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 300, 0, 32'h0, 0);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 301, 0, 32'h0, 0);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 400, 0, 32'h7FFF_FFFF, 0);
    send_fields(LEFT_DISABLE, RIGHT_HOMING, 400, 0, 32'h7FFF_FFFF, 0);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 660, 5, 32'hFFFF_FF00, 0);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 660, 5, 32'hFFFF_FF00, 0);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 660, 5, 32'hFFFF_FF00, 0);
    send_fields(LEFT_MANUAL, RIGHT_HOMING, 660, 0, 32'h8000_0000, 0);
    send_fields(LEFT_DISABLE, RIGHT_HOMING, 660, 0, 32'h8000_0000, 0);
    send_fields(LEFT_MANUAL, RIGHT_PLAIN, 660, 0, 32'h1234_5678, 0);
    drain_results();

    // Full homing run at power-on settings
    apply_settings(RST_STALL_THR, RST_DRIVE_OFFSET, RST_SETTLE, RST_OVERSHOOT,
                   RST_SPEED_THR, RST_ENGAGE);
    run_homing(2500);
    drain_results();

    apply_random_settings();
    run_free(100);
    drain_results();

    // One long pulse past the cycle wrap, no gaps on either side
    in_gap_pct  = 0;
    out_gap_pct = 0;
    apply_settings(65535, 65535, 0, 65535, 0, -660);
    drive_segment(SEG_PULSE, 2100, 0);
    drain_results();
    in_gap_pct  = 34;
    out_gap_pct = 34;

    apply_settings(0, 0, 65535, 0, 32767, 660);
    run_free(60);
    drain_results();

    apply_random_settings();
    run_free(80);
    drain_results();

    apply_random_settings();
    run_free(80);
    drain_results();

    if (sb.mismatches == 0 && sb.expected_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
